### sv/psd_pkg.sv
// ============================================================================
// psd_pkg: shared widths, types and constants
// Fixed-point widths for the point-to-segment squared distance pipeline.
// ============================================================================
package psd_pkg;

  // Fraction bits of the projection parameter t
  localparam int FRAC_BITS   = 16;

  // Coordinate and derived widths
  localparam int COORD_W     = 17;
  localparam int DIFF_W      = COORD_W + 1;          // span / offset
  localparam int MUL_W       = 2 * DIFF_W;           // one coordinate product
  localparam int LEN_W       = 2 * COORD_W + 1;      // squared span length
  localparam int DOT_W       = MUL_W + 1;            // dot product, signed
  localparam int T_W         = FRAC_BITS + 1;        // t in 0..1.0
  localparam int PROJ_W      = T_W + 1 + DIFF_W;     // t * span, signed
  localparam int DELTA_W     = PROJ_W - FRAC_BITS;   // point-to-nearest delta
  localparam int SQ_W        = LEN_W + 1;            // one squared delta
  localparam int DIST_W      = 35;                   // result width

  // Stream packing
  localparam int IN_FIELDS   = 6;
  localparam int IN_DATA_W   = ((IN_FIELDS * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((DIST_W + 7) / 8) * 8;

  // Pipeline depth
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 4;
  localparam int LATENCY      = FRONT_STAGES + FRAC_BITS + BACK_STAGES;
  localparam int CNT_W        = $clog2(LATENCY + 1);

  // How t is chosen for a transaction
  typedef enum logic [1:0] {
    TSEL_DIV,    // quotient from the divider
    TSEL_ZERO,   // projection at or before begin, or zero-length span
    TSEL_ONE     // projection at or beyond end
  } psd_tsel_t;

  // Values that ride alongside the divider
  typedef struct packed {
    logic [DIFF_W-1:0] sx;
    logic [DIFF_W-1:0] sy;
    logic [DIFF_W-1:0] ox;
    logic [DIFF_W-1:0] oy;
    psd_tsel_t         tsel;
  } psd_side_t;

endpackage

### sv/psd_front.sv
// ============================================================================
// psd_front: span, offset, squared length and dot product
// Four registered stages: differences, products, sums, t classification.
// ============================================================================
module psd_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [psd_pkg::COORD_W-1:0]   point_x,
  input  logic signed [psd_pkg::COORD_W-1:0]   point_y,
  input  logic signed [psd_pkg::COORD_W-1:0]   begin_x,
  input  logic signed [psd_pkg::COORD_W-1:0]   begin_y,
  input  logic signed [psd_pkg::COORD_W-1:0]   end_x,
  input  logic signed [psd_pkg::COORD_W-1:0]   end_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [psd_pkg::LEN_W-1:0]            out_rem,
  output logic [psd_pkg::LEN_W-1:0]            out_len,
  output psd_pkg::psd_side_t                   out_side
);

  localparam int DIFF_W = psd_pkg::DIFF_W;
  localparam int MUL_W  = psd_pkg::MUL_W;
  localparam int LEN_W  = psd_pkg::LEN_W;
  localparam int DOT_W  = psd_pkg::DOT_W;

  // Stage valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 1: span and offset
  logic signed [DIFF_W-1:0] sx_r, sy_r, ox_r, oy_r;
  logic signed [DIFF_W-1:0] sx_nxt, sy_nxt, ox_nxt, oy_nxt;

  assign sx_nxt = DIFF_W'(end_x)   - DIFF_W'(begin_x);
  assign sy_nxt = DIFF_W'(end_y)   - DIFF_W'(begin_y);
  assign ox_nxt = DIFF_W'(point_x) - DIFF_W'(begin_x);
  assign oy_nxt = DIFF_W'(point_y) - DIFF_W'(begin_y);

  // Stage 2: four products
  logic signed [MUL_W-1:0] sxx_r, syy_r, dxs_r, dys_r;
  logic signed [MUL_W-1:0] sxx_nxt, syy_nxt, dxs_nxt, dys_nxt;
  psd_pkg::psd_side_t      side2_r, side2_nxt;

  assign sxx_nxt = sx_r * sx_r;
  assign syy_nxt = sy_r * sy_r;
  assign dxs_nxt = ox_r * sx_r;
  assign dys_nxt = oy_r * sy_r;

  always_comb begin
    side2_nxt.sx   = sx_r;
    side2_nxt.sy   = sy_r;
    side2_nxt.ox   = ox_r;
    side2_nxt.oy   = oy_r;
    side2_nxt.tsel = psd_pkg::TSEL_DIV;
  end

  // Stage 3: squared length and dot product
  logic [LEN_W-1:0]        len3_r, len3_nxt;
  logic signed [DOT_W-1:0] dot3_r, dot3_nxt;
  logic [MUL_W-1:0]        len_sum;
  psd_pkg::psd_side_t      side3_r;

  assign len_sum  = sxx_r + syy_r;
  assign len3_nxt = len_sum[LEN_W-1:0];
  assign dot3_nxt = DOT_W'(dxs_r) + DOT_W'(dys_r);

  // Stage 4: pick t source, seed the divider remainder
  logic [LEN_W-1:0]   rem4_r, rem4_nxt;
  logic [LEN_W-1:0]   len4_r;
  psd_pkg::psd_side_t side4_r, side4_nxt;
  logic               dot_le_zero, dot_ge_len;

  assign dot_le_zero = dot3_r[DOT_W-1] || (dot3_r == '0);
  assign dot_ge_len  = dot3_r >= $signed({{(DOT_W-LEN_W){1'b0}}, len3_r});

  always_comb begin
    side4_nxt = side3_r;
    rem4_nxt  = '0;
    if (dot_le_zero) begin
      side4_nxt.tsel = psd_pkg::TSEL_ZERO;
    end else if (dot_ge_len) begin
      side4_nxt.tsel = psd_pkg::TSEL_ONE;
    end else begin
      side4_nxt.tsel = psd_pkg::TSEL_DIV;
      rem4_nxt       = dot3_r[LEN_W-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
    if (rdy2 && v1_r) begin
      sxx_r   <= sxx_nxt;
      syy_r   <= syy_nxt;
      dxs_r   <= dxs_nxt;
      dys_r   <= dys_nxt;
      side2_r <= side2_nxt;
    end
    if (rdy3 && v2_r) begin
      len3_r  <= len3_nxt;
      dot3_r  <= dot3_nxt;
      side3_r <= side2_r;
    end
    if (rdy4 && v3_r) begin
      rem4_r  <= rem4_nxt;
      len4_r  <= len3_r;
      side4_r <= side4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_rem   = rem4_r;
  assign out_len   = len4_r;
  assign out_side  = side4_r;

  // A zero-length span always takes the begin point
  a_zero_len_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && len4_r == '0) |-> side4_r.tsel == psd_pkg::TSEL_ZERO)
    else $error("zero-length span not routed to t = 0");

  // Divider is only seeded with a proper fraction
  a_seed_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && side4_r.tsel == psd_pkg::TSEL_DIV) |-> (rem4_r < len4_r))
    else $error("divider seed not below divisor");

endmodule

### sv/psd_div.sv
// ============================================================================
// psd_div: pipelined restoring divider for the projection fraction
// One quotient bit per stage, FRAC_BITS stages, one transaction per cycle while out_ready does not stall it.
// ============================================================================
module psd_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [psd_pkg::LEN_W-1:0]         in_rem,
  input  logic [psd_pkg::LEN_W-1:0]         in_len,
  input  psd_pkg::psd_side_t                in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [psd_pkg::FRAC_BITS-1:0]     out_quot,
  output psd_pkg::psd_side_t                out_side
);

  localparam int N     = psd_pkg::FRAC_BITS;
  localparam int LEN_W = psd_pkg::LEN_W;

  // Stage registers
  logic                 v_r    [N];
  logic [LEN_W-1:0]     rem_r  [N];
  logic [LEN_W-1:0]     len_r  [N];
  logic [N-1:0]         q_r    [N];
  psd_pkg::psd_side_t   side_r [N];

  // Stage sources and next values
  logic                 src_v    [N];
  logic [LEN_W-1:0]     src_rem  [N];
  logic [LEN_W-1:0]     src_len  [N];
  logic [N-1:0]         src_q    [N];
  psd_pkg::psd_side_t   src_side [N];
  logic [LEN_W-1:0]     rem_nxt  [N];
  logic [N-1:0]         q_nxt    [N];
  logic                 rdy      [N];

  // Each stage takes from the one before it
  always_comb begin
    src_v[0]    = in_valid;
    src_rem[0]  = in_rem;
    src_len[0]  = in_len;
    src_q[0]    = '0;
    src_side[0] = in_side;
    for (int k = 1; k < N; k++) begin
      src_v[k]    = v_r[k-1];
      src_rem[k]  = rem_r[k-1];
      src_len[k]  = len_r[k-1];
      src_q[k]    = q_r[k-1];
      src_side[k] = side_r[k-1];
    end
  end

  // Shift, trial subtract, restore
  always_comb begin
    logic [LEN_W:0] r2;
    logic [LEN_W:0] diff;
    logic           ge;
    for (int k = 0; k < N; k++) begin
      r2         = {src_rem[k], 1'b0};
      diff       = r2 - {1'b0, src_len[k]};
      ge         = r2 >= {1'b0, src_len[k]};
      rem_nxt[k] = ge ? diff[LEN_W-1:0] : r2[LEN_W-1:0];
      q_nxt[k]   = {src_q[k][N-2:0], ge};
    end
  end

  // Ready chain from the output back
  always_comb begin
    rdy[N-1] = !v_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) v_r[k] <= src_v[k];
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (rdy[k] && src_v[k]) begin
        rem_r[k]  <= rem_nxt[k];
        len_r[k]  <= src_len[k];
        q_r[k]    <= q_nxt[k];
        side_r[k] <= src_side[k];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_quot  = q_r[N-1];
  assign out_side  = side_r[N-1];

  // Final remainder is always below the divisor
  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[N-1] && side_r[N-1].tsel == psd_pkg::TSEL_DIV) |-> (rem_r[N-1] < len_r[N-1]))
    else $error("divider remainder out of range");

endmodule

### sv/psd_back.sv
// ============================================================================
// psd_back: nearest point, deltas, squares and final sum
// Four registered stages: t * span, rounded deltas, squares, output sum.
// ============================================================================
module psd_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [psd_pkg::FRAC_BITS-1:0]     in_quot,
  input  psd_pkg::psd_side_t                in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [psd_pkg::DIST_W-1:0]        out_dist
);

  localparam int FRAC_BITS = psd_pkg::FRAC_BITS;
  localparam int DIFF_W    = psd_pkg::DIFF_W;
  localparam int T_W       = psd_pkg::T_W;
  localparam int PROJ_W    = psd_pkg::PROJ_W;
  localparam int DELTA_W   = psd_pkg::DELTA_W;
  localparam int SQ_W      = psd_pkg::SQ_W;
  localparam int DIST_W    = psd_pkg::DIST_W;

  localparam logic [T_W-1:0]           T_ONE = T_W'(1) << FRAC_BITS;
  localparam logic signed [PROJ_W-1:0] HALF  = PROJ_W'(1) << (FRAC_BITS - 1);

  // Valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 1: select t, scale the span
  logic [T_W-1:0]            t_sel;
  logic signed [PROJ_W-1:0]  px_r, py_r, px_nxt, py_nxt;
  logic signed [DIFF_W-1:0]  ox1_r, oy1_r;

  always_comb begin
    case (in_side.tsel)
      psd_pkg::TSEL_ZERO: t_sel = '0;
      psd_pkg::TSEL_ONE:  t_sel = T_ONE;
      default:            t_sel = {1'b0, in_quot};
    endcase
  end

  assign px_nxt = $signed({1'b0, t_sel}) * $signed(in_side.sx);
  assign py_nxt = $signed({1'b0, t_sel}) * $signed(in_side.sy);

  // Stage 2: round to nearest, delta from the offset
  logic signed [PROJ_W-1:0]  rx_sh, ry_sh;
  logic signed [DELTA_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;

  assign rx_sh  = (px_r + HALF) >>> FRAC_BITS;
  assign ry_sh  = (py_r + HALF) >>> FRAC_BITS;
  assign dx_nxt = DELTA_W'(ox1_r) - rx_sh[DELTA_W-1:0];
  assign dy_nxt = DELTA_W'(oy1_r) - ry_sh[DELTA_W-1:0];

  // Stage 3: squares
  logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0]             sqx_r, sqy_r;

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  // Stage 4: sum
  logic [SQ_W-1:0]   dist_sum;
  logic [DIST_W-1:0] dist_r;

  assign dist_sum = sqx_r + sqy_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      ox1_r <= $signed(in_side.ox);
      oy1_r <= $signed(in_side.oy);
    end
    if (rdy2 && v1_r) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (rdy3 && v2_r) begin
      sqx_r <= sqx_full[SQ_W-1:0];
      sqy_r <= sqy_full[SQ_W-1:0];
    end
    if (rdy4 && v3_r) begin
      dist_r <= dist_sum[DIST_W-1:0];
    end
  end

  assign out_valid = v4_r;
  assign out_dist  = dist_r;

endmodule

### sv/point_segment_distance_sq_core.sv
// Pipeline: 4 setup stages, FRAC_BITS = 16 divider stages, 4 output stages.
// Throughput: one transaction per cycle when out_tready does not stall it;
//   the divider resolves one quotient bit per stage, so its depth sets the
//   latency, not the rate.
// Reset: rst_n clears every stage valid bit; data registers are not reset.
// ============================================================================
// point_segment_distance_sq_core: squared distance from a point to a segment
// Stream-in of point and segment end points, stream-out of squared distance.
// ============================================================================
module point_segment_distance_sq_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: point_x, point_y, begin_x, begin_y, end_x, end_y, zero pad
  input  logic [psd_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: distance_sq, zero pad
  output logic [psd_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);

  localparam int COORD_W = psd_pkg::COORD_W;
  localparam int LEN_W   = psd_pkg::LEN_W;
  localparam int DIST_W  = psd_pkg::DIST_W;
  localparam int CNT_W   = psd_pkg::CNT_W;

  // Unpack input fields
  logic signed [COORD_W-1:0] point_x, point_y, begin_x, begin_y, end_x, end_y;

  assign point_x = $signed(in_tdata[0*COORD_W +: COORD_W]);
  assign point_y = $signed(in_tdata[1*COORD_W +: COORD_W]);
  assign begin_x = $signed(in_tdata[2*COORD_W +: COORD_W]);
  assign begin_y = $signed(in_tdata[3*COORD_W +: COORD_W]);
  assign end_x   = $signed(in_tdata[4*COORD_W +: COORD_W]);
  assign end_y   = $signed(in_tdata[5*COORD_W +: COORD_W]);

  // Front to divider
  logic               fd_valid, fd_ready;
  logic [LEN_W-1:0]   fd_rem, fd_len;
  psd_pkg::psd_side_t fd_side;

  // Divider to back
  logic                            db_valid, db_ready;
  logic [psd_pkg::FRAC_BITS-1:0]   db_quot;
  psd_pkg::psd_side_t              db_side;

  logic [DIST_W-1:0] dist_sq;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .point_x   (point_x),
    .point_y   (point_y),
    .begin_x   (begin_x),
    .begin_y   (begin_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (fd_valid),
    .out_ready (fd_ready),
    .out_rem   (fd_rem),
    .out_len   (fd_len),
    .out_side  (fd_side)
  );

  psd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fd_valid),
    .in_ready  (fd_ready),
    .in_rem    (fd_rem),
    .in_len    (fd_len),
    .in_side   (fd_side),
    .out_valid (db_valid),
    .out_ready (db_ready),
    .out_quot  (db_quot),
    .out_side  (db_side)
  );

  psd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (db_valid),
    .in_ready  (db_ready),
    .in_quot   (db_quot),
    .in_side   (db_side),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dist  (dist_sq)
  );

  assign out_tdata = {{(psd_pkg::OUT_DATA_W - DIST_W){1'b0}}, dist_sq};

  // Transactions in flight, for checking only
  logic [CNT_W-1:0] inflight_r, inflight_nxt;
  logic             in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_fire && !out_fire) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end else if (out_fire && !in_fire) begin
      inflight_nxt = inflight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // The pipeline never holds more transactions than it has stages
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(psd_pkg::LATENCY))
    else $error("more transactions in flight than pipeline stages");

  // No result appears without a transaction behind it
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (inflight_r != '0))
    else $error("output valid with nothing in flight");

endmodule
